// ===== sv/spsg_pkg.sv =====
// Shared types and constants of the H.264 SPS geometry parser.
// No dependencies; imported by the top level.
package spsg_pkg;

  // Syntax element sequence of the SPS walk
  typedef enum logic [6:0] {
    ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPARATE, ST_DEPTHL,
    ST_DEPTHC, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTA, ST_LOG2FN, ST_POCTYPE,
    ST_POCLSB, ST_DPOAZ, ST_OFFNR, ST_OFFTB, ST_NCYC, ST_CYC, ST_MAXREF, ST_GAPS,
    ST_WMBS, ST_HMAP, ST_FMO, ST_MBAFF, ST_D8, ST_CROP, ST_CL, ST_CR, ST_CT, ST_CB,
    ST_VUI, ST_AR, ST_ARIDC, ST_SAR, ST_OVS, ST_OVA, ST_VST, ST_VFMT, ST_CDP, ST_CD,
    ST_CLOC, ST_CLT, ST_CLB, ST_TIM, ST_UNITS, ST_SCALE, ST_DONE
  } step_t;

  // Element decode mode: fixed field, exp-Golomb prefix, exp-Golomb suffix
  typedef enum logic [1:0] {K_FIXED, K_PREFIX, K_SUFFIX} kind_t;

  localparam int unsigned RATE_OUT_W   = 48;
  localparam logic [7:0]  ARIDC_EXT_SAR = 8'd255;
  localparam logic [5:0]  MAX_ZERO_RUN  = 6'd31;
  localparam logic [31:0] CHROMA_444    = 32'd3;

  // Fixed field width per element; zero marks an exp-Golomb code
  function automatic logic [5:0] step_width(step_t s);
    logic [5:0] w;
    case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_ARIDC: w = 6'd8;
      ST_SAR, ST_UNITS, ST_SCALE:                w = 6'd32;
      ST_CD:                                     w = 6'd24;
      ST_VFMT:                                   w = 6'd4;
      ST_SEPARATE, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DPOAZ, ST_GAPS, ST_FMO,
      ST_MBAFF, ST_D8, ST_CROP, ST_VUI, ST_AR, ST_OVS, ST_OVA, ST_VST, ST_CDP,
      ST_CLOC, ST_TIM:                           w = 6'd1;
      default:                                   w = 6'd0;
    endcase
    return w;
  endfunction

  // Profiles that carry chroma format and scaling matrices
  function automatic logic high_profile(logic [7:0] p);
    logic h;
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
      8'd128, 8'd134, 8'd135, 8'd138, 8'd139: h = 1'b1;
      default:                                h = 1'b0;
    endcase
    return h;
  endfunction

endpackage

// ===== sv/spsg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the SPS parser for the frame rate quotient.
module spsg_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    rem_sh     = {rem_r, quo_r[NUM_W-1]};
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(NUM_W);
      rem_nxt    = '0;
      den_nxt    = den;
      quo_nxt    = num;
    end else if (active_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== sv/h264_sps_geometry_parser.sv =====
// H.264 SPS geometry parser: walks SPS RBSP syntax one bit per cycle while a byte is held.
// Depends on spsg_pkg and spsg_div.
// The bit walker shifts out each byte and takes the next one on its last bit.
// After the last byte: the evaluation state, the divider state when timing is present
// and the parse is ok, then a result load once the output is free; input waits until then.
// Synchronous active-low reset returns the walker to the start of an SPS.
module h264_sps_geometry_parser #(
  parameter int unsigned RATE_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] parse_ok, [32:1] pic_width, [64:33] pic_height, [65] interlaced,
  // [66] rate_present, [114:67] frame_rate_q16, [119:115] zero
  output logic [119:0] out_tdata
);
  import spsg_pkg::*;

  localparam int unsigned NUM_W = 32 + RATE_FRAC_BITS;
  localparam int unsigned DEN_W = 33;

  typedef enum logic [2:0] {S_IDLE, S_BITS, S_EVAL, S_DIV, S_OUT} state_t;

  typedef struct packed {
    logic [47:0] rate;
    logic        rate_present;
    logic        interlaced;
    logic [31:0] height;
    logic [31:0] width;
    logic        ok;
  } result_t;

  state_t      state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  step_t       step_r, step_nxt;
  kind_t       kind_r, kind_nxt;
  logic [5:0]  zrun_r, zrun_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [7:0]  profile_r, profile_nxt;
  logic [31:0] chroma_r, chroma_nxt;
  logic        sep_r, sep_nxt;
  logic [31:0] loop_r, loop_nxt;
  logic [7:0]  slast_r, slast_nxt;
  logic [3:0]  list_r, list_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic        frame_r, frame_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] scale_r, scale_nxt;
  logic        failed_r, failed_nxt;

  logic             dv_start, dv_done;
  logic [NUM_W-1:0] dv_quot;
  logic [63:0]      q64;

  logic        in_acc, out_free, bit_in, cplt, next_list, ok_now;
  logic [31:0] acc_new, cval, loop_inc;
  logic [5:0]  left_dec, wid;
  logic [7:0]  d8, sn8;
  logic [1:0]  sh_y;
  logic        sh_x;
  step_t       tgt;

  assign in_tready = (state_r == S_IDLE) || (state_r == S_BITS && bit_cnt_r == 3'd7 && !last_r);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign ok_now    = !failed_r && step_r == ST_DONE;
  assign dv_start  = (state_r == S_EVAL) && ok_now && tick_r != 32'd0;
  assign q64       = 64'(dv_quot);

  always_comb begin
    state_nxt = state_r; byte_nxt = byte_r; last_nxt = last_r; bit_cnt_nxt = bit_cnt_r;
    out_valid_nxt = out_valid_r; res_nxt = res_r;
    step_nxt = step_r; kind_nxt = kind_r; zrun_nxt = zrun_r; acc_nxt = acc_r;
    left_nxt = left_r; profile_nxt = profile_r; chroma_nxt = chroma_r; sep_nxt = sep_r;
    loop_nxt = loop_r; slast_nxt = slast_r; list_nxt = list_r; width_nxt = width_r;
    height_nxt = height_r; frame_nxt = frame_r; tick_nxt = tick_r; scale_nxt = scale_r;
    failed_nxt = failed_r;
    bit_in = byte_r[7];
    cplt = 1'b0; next_list = 1'b0; cval = '0; tgt = ST_DONE;
    acc_new  = {acc_r[30:0], bit_in};
    left_dec = left_r - 6'd1;
    loop_inc = loop_r + 32'd1;
    d8 = '0; sn8 = '0; wid = '0;
    sh_x = !(sep_r || chroma_r == 32'd0) && (chroma_r == 32'd1 || chroma_r == 32'd2);
    sh_y = 2'(!sep_r && chroma_r == 32'd1) + 2'(!frame_r);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_tdata; last_nxt = in_tlast; bit_cnt_nxt = '0;
          state_nxt = S_BITS;
        end
      end
      S_BITS: begin
        byte_nxt    = {byte_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          if (last_r) state_nxt = S_EVAL;
          else if (in_acc) begin
            byte_nxt = in_tdata; last_nxt = in_tlast; bit_cnt_nxt = '0;
          end else state_nxt = S_IDLE;
        end
        // one syntax bit
        if (!failed_r && step_r != ST_DONE) begin
          if (kind_r == K_PREFIX) begin
            if (!bit_in) begin
              zrun_nxt = zrun_r + 6'd1;
              if (zrun_r == MAX_ZERO_RUN) failed_nxt = 1'b1;
            end else if (zrun_r == 6'd0) begin
              cplt = 1'b1;
            end else begin
              left_nxt = zrun_r; acc_nxt = '0; kind_nxt = K_SUFFIX;
            end
          end else begin
            acc_nxt = acc_new; left_nxt = left_dec;
            if (left_dec == 6'd0) begin
              cplt = 1'b1;
              cval = (kind_r == K_SUFFIX) ? ~(32'hFFFF_FFFF << zrun_r[4:0]) + acc_new
                                          : acc_new;
            end
          end
        end
        if (cplt) begin
          tgt = step_t'(7'(step_r + 7'd1));
          case (step_r)
            ST_PROFILE: profile_nxt = cval[7:0];
            ST_SPSID:   tgt = high_profile(profile_r) ? ST_CHROMA : ST_LOG2FN;
            ST_CHROMA: begin
              chroma_nxt = cval;
              tgt = (cval == CHROMA_444) ? ST_SEPARATE : ST_DEPTHL;
            end
            ST_SEPARATE: sep_nxt = cval[0];
            ST_MATRIX: begin
              if (cval != 32'd0) begin list_nxt = '0; tgt = ST_LISTFLAG; end
              else tgt = ST_LOG2FN;
            end
            ST_LISTFLAG: begin
              if (cval != 32'd0) begin
                loop_nxt = '0; slast_nxt = 8'd8; tgt = ST_DELTA;
              end else next_list = 1'b1;
            end
            ST_DELTA: begin
              d8  = cval[0] ? cval[8:1] + 8'd1 : 8'd0 - cval[8:1];
              sn8 = slast_r + d8;
              if (sn8 != 8'd0) slast_nxt = sn8;
              loop_nxt = loop_inc;
              if (sn8 == 8'd0 || loop_inc >= ((list_r < 4'd6) ? 32'd16 : 32'd64))
                next_list = 1'b1;
              else tgt = ST_DELTA;
            end
            ST_POCTYPE: tgt = (cval == 32'd0) ? ST_POCLSB :
                              (cval == 32'd1) ? ST_DPOAZ : ST_MAXREF;
            ST_POCLSB: tgt = ST_MAXREF;
            ST_NCYC: begin
              loop_nxt = cval; tgt = (cval != 32'd0) ? ST_CYC : ST_MAXREF;
            end
            ST_CYC: begin
              loop_nxt = loop_r - 32'd1;
              tgt = (loop_r != 32'd1) ? ST_CYC : ST_MAXREF;
            end
            ST_WMBS: width_nxt  = (cval + 32'd1) << 4;
            ST_HMAP: height_nxt = (cval + 32'd1) << 4;
            ST_FMO: begin
              frame_nxt = cval[0];
              if (!cval[0]) height_nxt = height_r << 1;
              tgt = cval[0] ? ST_D8 : ST_MBAFF;
            end
            ST_CROP:      tgt = (cval != 32'd0) ? ST_CL : ST_VUI;
            ST_CL, ST_CR: width_nxt  = width_r - (cval << sh_x);
            ST_CT, ST_CB: height_nxt = height_r - (cval << sh_y);
            ST_VUI:   tgt = (cval != 32'd0) ? ST_AR : ST_DONE;
            ST_AR:    tgt = (cval != 32'd0) ? ST_ARIDC : ST_OVS;
            ST_ARIDC: tgt = (cval[7:0] == ARIDC_EXT_SAR && cval[31:8] == 24'd0)
                            ? ST_SAR : ST_OVS;
            ST_OVS:   tgt = (cval != 32'd0) ? ST_OVA : ST_VST;
            ST_VST:   tgt = (cval != 32'd0) ? ST_VFMT : ST_CLOC;
            ST_CDP:   tgt = (cval != 32'd0) ? ST_CD : ST_CLOC;
            ST_CLOC:  tgt = (cval != 32'd0) ? ST_CLT : ST_TIM;
            ST_TIM:   tgt = (cval != 32'd0) ? ST_UNITS : ST_DONE;
            ST_UNITS: tick_nxt = cval;
            ST_SCALE: begin scale_nxt = cval; tgt = ST_DONE; end
            ST_SAR:   tgt = ST_OVS;
            ST_OVA:   tgt = ST_VST;
            ST_CD:    tgt = ST_CLOC;
            ST_CLB:   tgt = ST_TIM;
            default:  tgt = step_t'(7'(step_r + 7'd1));
          endcase
          if (next_list) begin
            list_nxt = list_r + 4'd1;
            tgt = ((list_r + 4'd1) < ((chroma_r == CHROMA_444) ? 4'd12 : 4'd8))
                  ? ST_LISTFLAG : ST_LOG2FN;
          end
          // start the next element
          wid = step_width(tgt);
          step_nxt = tgt; acc_nxt = '0; zrun_nxt = '0;
          if (tgt != ST_DONE) begin
            left_nxt = wid;
            kind_nxt = (wid != 6'd0) ? K_FIXED : K_PREFIX;
          end
        end
      end
      S_EVAL:  state_nxt = dv_start ? S_DIV : S_OUT;
      S_DIV:   if (dv_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          res_nxt = '0;
          if (ok_now) begin
            res_nxt.ok = 1'b1; res_nxt.width = width_r; res_nxt.height = height_r;
            res_nxt.interlaced = !frame_r;
            if (tick_r != 32'd0) begin
              res_nxt.rate_present = 1'b1;
              res_nxt.rate = (q64[63:RATE_OUT_W] != '0) ? '1 : q64[RATE_OUT_W-1:0];
            end
          end
          out_valid_nxt = 1'b1;
          // back to the start of an SPS
          step_nxt = ST_PROFILE; kind_nxt = K_FIXED; zrun_nxt = '0; acc_nxt = '0;
          left_nxt = step_width(ST_PROFILE); profile_nxt = '0; chroma_nxt = 32'd1;
          sep_nxt = 1'b0; loop_nxt = '0; slast_nxt = 8'd8; list_nxt = '0;
          width_nxt = '0; height_nxt = '0; frame_nxt = 1'b0; tick_nxt = '0;
          scale_nxt = '0; failed_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; bit_cnt_r <= '0; last_r <= 1'b0; out_valid_r <= 1'b0;
      step_r <= ST_PROFILE; kind_r <= K_FIXED; zrun_r <= '0; acc_r <= '0;
      left_r <= step_width(ST_PROFILE); profile_r <= '0; chroma_r <= 32'd1;
      sep_r <= 1'b0; loop_r <= '0; slast_r <= 8'd8; list_r <= '0;
      width_r <= '0; height_r <= '0; frame_r <= 1'b0; tick_r <= '0;
      scale_r <= '0; failed_r <= 1'b0;
    end else begin
      state_r <= state_nxt; bit_cnt_r <= bit_cnt_nxt; last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
      step_r <= step_nxt; kind_r <= kind_nxt; zrun_r <= zrun_nxt; acc_r <= acc_nxt;
      left_r <= left_nxt; profile_r <= profile_nxt; chroma_r <= chroma_nxt;
      sep_r <= sep_nxt; loop_r <= loop_nxt; slast_r <= slast_nxt; list_r <= list_nxt;
      width_r <= width_nxt; height_r <= height_nxt; frame_r <= frame_nxt;
      tick_r <= tick_nxt; scale_r <= scale_nxt; failed_r <= failed_nxt;
    end
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
  end

  spsg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (NUM_W'(scale_r) << RATE_FRAC_BITS),
    .den   ({1'b0, tick_r} << 1),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && state_r != S_OUT) |=> failed_r)
    else $error("failure flag dropped mid-SPS");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> state_r == S_DIV)
    else $error("divider finished outside divide phase");
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.ok) |-> (res_r.width == 32'd0 && !res_r.rate_present))
    else $error("failed result carries data");
  a_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.rate_present) |-> res_r.rate == '0)
    else $error("rate without timing");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_free) |=> (state_r == S_OUT))
    else $error("result stage left while output blocked");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for h264_sps_geometry_parser: streams SPS byte frames
// and checks each geometry result against a bit-serial predictor. Needs spsg_pkg.
module tb;
  import spsg_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int RAND_BYTES  = 1650;

  typedef struct packed {
    logic [4:0]  pad;
    logic [47:0] rate;
    logic        rate_ok;
    logic        ilace;
    logic [31:0] height;
    logic [31:0] width;
    logic        ok;
  } geom_t;

  typedef struct {
    logic [7:0] d;
    logic       l;
    logic       typed;
    geom_t      g;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;

  h264_sps_geometry_parser u_top (.*);

  always #2 clk = ~clk;

  // predictor state
  step_t       p_step;
  kind_t       p_kind;
  logic [31:0] p_zrun, p_acc, p_left, p_prof, p_chroma, p_sep, p_cnt, p_slast, p_snext;
  logic [31:0] p_w, p_h, p_fonly, p_units, p_scale, p_bad, p_list;

  geom_t geom_q[$];
  bit    bits_q[$];
  logic [7:0] frame_q[$];
  int    errors = 0, bytes_sent = 0, frames_ok = 0, frames_bad = 0;
  bit    quiet = 1'b0, hold_req = 1'b0;
  int    hold_left = 0, stall_cyc = 0;

  function automatic logic [5:0] elem_width(step_t s);
    case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_ARIDC: return 6'd8;
      ST_SAR, ST_UNITS, ST_SCALE:                return 6'd32;
      ST_CD:                                     return 6'd24;
      ST_VFMT:                                   return 6'd4;
      ST_SEPARATE, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DPOAZ, ST_GAPS, ST_FMO,
      ST_MBAFF, ST_D8, ST_CROP, ST_VUI, ST_AR, ST_OVS, ST_OVA, ST_VST, ST_CDP,
      ST_CLOC, ST_TIM:                           return 6'd1;
      default:                                   return 6'd0;
    endcase
  endfunction

  function automatic bit is_high(logic [7:0] p);
    return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
                     8'd128, 8'd134, 8'd135, 8'd138, 8'd139};
  endfunction

  function automatic void enter(step_t s);
    p_step = s;
    p_acc  = 0;
    p_zrun = 0;
    if (s != ST_DONE) begin
      p_left = elem_width(s);
      p_kind = (p_left != 0) ? K_FIXED : K_PREFIX;
    end
  endfunction

  function automatic void sps_restart();
    p_prof = 0; p_chroma = 1; p_sep = 0; p_cnt = 0; p_slast = 8; p_snext = 8;
    p_w = 0; p_h = 0; p_fonly = 0; p_units = 0; p_scale = 0; p_bad = 0; p_list = 0;
    enter(ST_PROFILE);
  endfunction

  function automatic void advance_list();
    p_list++;
    if (p_list < ((p_chroma == CHROMA_444) ? 32'd12 : 32'd8)) enter(ST_LISTFLAG);
    else enter(ST_LOG2FN);
  endfunction

  function automatic void close_elem(logic [31:0] v);
    logic [31:0] delta, ux, uy;
    step_t s;
    s  = p_step;
    ux = (p_sep[0] || p_chroma == 0) ? 32'd1 : ((p_chroma == 1 || p_chroma == 2) ? 32'd2 : 32'd1);
    uy = (!p_sep[0] && p_chroma == 1) ? 32'd2 : 32'd1;
    uy = uy * (32'd2 - p_fonly);
    case (s)
      ST_PROFILE: begin p_prof = v & 255; enter(ST_CONSTR); end
      ST_SPSID:   enter(is_high(p_prof[7:0]) ? ST_CHROMA : ST_LOG2FN);
      ST_CHROMA:  begin p_chroma = v; enter(v == CHROMA_444 ? ST_SEPARATE : ST_DEPTHL); end
      ST_SEPARATE: begin p_sep = v & 1; enter(ST_DEPTHL); end
      ST_MATRIX: begin
        if (v != 0) begin p_list = 0; enter(ST_LISTFLAG); end
        else enter(ST_LOG2FN);
      end
      ST_LISTFLAG: begin
        if (v != 0) begin
          p_cnt = 0; p_slast = 8; p_snext = 8; enter(ST_DELTA);
        end else advance_list();
      end
      ST_DELTA: begin
        delta   = v[0] ? ((v + 32'd1) >> 1) : (32'd0 - (v >> 1));
        p_snext = (p_slast + delta) & 255;
        if (p_snext != 0) p_slast = p_snext;
        p_cnt++;
        if (p_snext == 0 || p_cnt >= ((p_list < 6) ? 32'd16 : 32'd64)) advance_list();
        else enter(ST_DELTA);
      end
      ST_POCTYPE: enter(v == 0 ? ST_POCLSB : (v == 1 ? ST_DPOAZ : ST_MAXREF));
      ST_POCLSB:  enter(ST_MAXREF);
      ST_NCYC:    begin p_cnt = v; enter(v != 0 ? ST_CYC : ST_MAXREF); end
      ST_CYC:     begin p_cnt--; enter(p_cnt != 0 ? ST_CYC : ST_MAXREF); end
      ST_WMBS:    begin p_w = (v + 1) * 16; enter(ST_HMAP); end
      ST_HMAP:    begin p_h = (v + 1) * 16; enter(ST_FMO); end
      ST_FMO: begin
        p_fonly = v & 1;
        p_h = p_h * (32'd2 - p_fonly);
        enter(p_fonly[0] ? ST_D8 : ST_MBAFF);
      end
      ST_CROP:      enter(v != 0 ? ST_CL : ST_VUI);
      ST_CL, ST_CR: begin p_w = p_w - v * ux; enter(step_t'(s + 1)); end
      ST_CT, ST_CB: begin p_h = p_h - v * uy; enter(step_t'(s + 1)); end
      ST_VUI:   enter(v != 0 ? ST_AR : ST_DONE);
      ST_AR:    enter(v != 0 ? ST_ARIDC : ST_OVS);
      ST_ARIDC: enter(v[7:0] == ARIDC_EXT_SAR && v[31:8] == 0 ? ST_SAR : ST_OVS);
      ST_OVS:   enter(v != 0 ? ST_OVA : ST_VST);
      ST_VST:   enter(v != 0 ? ST_VFMT : ST_CLOC);
      ST_CDP:   enter(v != 0 ? ST_CD : ST_CLOC);
      ST_CLOC:  enter(v != 0 ? ST_CLT : ST_TIM);
      ST_TIM:   enter(v != 0 ? ST_UNITS : ST_DONE);
      ST_UNITS: begin p_units = v; enter(ST_SCALE); end
      ST_SCALE: begin p_scale = v; enter(ST_DONE); end
      ST_SAR:   enter(ST_OVS);
      ST_OVA:   enter(ST_VST);
      ST_CD:    enter(ST_CLOC);
      ST_CLB:   enter(ST_TIM);
      default:  enter(step_t'(s + 1));
    endcase
  endfunction

  function automatic void walk_bit(logic b);
    if (p_bad != 0 || p_step == ST_DONE) return;
    if (p_kind == K_PREFIX) begin
      if (!b) begin
        p_zrun++;
        if (p_zrun > MAX_ZERO_RUN) p_bad = 1;
      end else if (p_zrun == 0) close_elem(0);
      else begin
        p_left = p_zrun; p_acc = 0; p_kind = K_SUFFIX;
      end
      return;
    end
    p_acc = (p_acc << 1) | b;
    p_left--;
    if (p_left == 0) begin
      if (p_kind == K_SUFFIX) close_elem(((32'd1 << p_zrun[4:0]) - 1) + p_acc);
      else close_elem(p_acc);
    end
  endfunction

  // Returns 1 when the byte closes an SPS; g then holds the predicted geometry.
  function automatic bit parse_byte(logic [7:0] d, logic l, output geom_t g);
    logic [63:0] q;
    g = '0;
    for (int i = 7; i >= 0; i--) walk_bit(d[i]);
    if (!l) return 0;
    if (p_bad == 0 && p_step == ST_DONE) begin
      g.ok = 1; g.width = p_w; g.height = p_h; g.ilace = (p_fonly == 0);
      if (p_units != 0) begin
        q = ({32'd0, p_scale} << 16) / (64'd2 * p_units);
        g.rate_ok = 1;
        g.rate = (q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
      end
    end
    sps_restart();
    return 1;
  endfunction

  task automatic send(logic [7:0] d, logic l, logic typed = 0, geom_t tg = '0);
    geom_t g;
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= d; in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(d, l, g)) begin
      if (typed) g = tg;
      geom_q.insert(geom_q.size(), g);
      if (g.ok) frames_ok++; else frames_bad++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (geom_q.size() > 0) @(negedge clk);
  endtask

  // bitstream writer
  task automatic put(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bits_q.insert(bits_q.size(), v[i]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [32:0] c;
    int n;
    c = {1'b0, v} + 33'd1;
    n = 0;
    for (int i = 0; i <= 32; i++) if (c[i]) n = i;
    put(0, n);
    put(c, n + 1);
  endtask

  function automatic logic [31:0] pick_ue(bit wide);
    if (wide && $urandom_range(0, 3) == 0) return $urandom();
    if (wide) return $urandom_range(0, 2) == 0 ? 32'hFFFF_FFFE : $urandom_range(0, 4000);
    return $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom_range(0, 6);
  endfunction

  // Build one SPS frame into frame_q: well-formed with random content,
  // optionally truncated. Wide picks extreme field values.
  task automatic build_sps(bit wide);
    logic [7:0] prof;
    logic [7:0] hp[13] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 134, 135, 138, 139};
    int chroma, poc, nlists, ncyc;
    bits_q.delete();
    frame_q.delete();
    prof = ($urandom_range(0, 1) == 0) ? hp[$urandom_range(0, 12)] : 8'($urandom());
    put(prof, 8); put($urandom(), 8); put($urandom(), 8);
    put_ue(pick_ue(0));
    if (is_high(prof)) begin
      chroma = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
      put_ue(chroma);
      if (chroma == 3) put($urandom(), 1);
      put_ue(pick_ue(0)); put_ue(pick_ue(0)); put($urandom(), 1);
      if ($urandom_range(0, 3) == 0) begin
        put(1, 1);
        nlists = (chroma == 3) ? 12 : 8;
        for (int k = 0; k < nlists; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            put(1, 1);
            for (int j = 0; j < (k < 6 ? 16 : 64); j++) put_ue($urandom_range(0, 20));
          end else put(0, 1);
        end
      end else put(0, 1);
    end
    put_ue(pick_ue(0));
    poc = $urandom_range(0, 3);
    put_ue(poc);
    if (poc == 0) put_ue(pick_ue(0));
    else if (poc == 1) begin
      put($urandom(), 1); put_ue(pick_ue(0)); put_ue(pick_ue(0));
      ncyc = $urandom_range(0, 4);
      put_ue(ncyc);
      repeat (ncyc) put_ue(pick_ue(0));
    end
    put_ue(pick_ue(0)); put($urandom(), 1);
    put_ue(pick_ue(wide)); put_ue(pick_ue(wide));
    put($urandom(), 1);
    if (!bits_q[bits_q.size() - 1]) put($urandom(), 1);
    put($urandom(), 1);
    if ($urandom_range(0, 1)) begin
      put(1, 1);
      repeat (4) put_ue(pick_ue(wide));
    end else put(0, 1);
    if ($urandom_range(0, 9) < 7) begin
      put(1, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1);
        if ($urandom_range(0, 2) == 0) begin put(255, 8); put($urandom(), 32); end
        else put($urandom(), 8);
      end else put(0, 1);
      if ($urandom_range(0, 1)) begin put(1, 1); put($urandom(), 1); end else put(0, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1); put($urandom(), 4);
        if ($urandom_range(0, 1)) begin put(1, 1); put($urandom(), 24); end else put(0, 1);
      end else put(0, 1);
      if ($urandom_range(0, 1)) begin
        put(1, 1); put_ue(pick_ue(0)); put_ue(pick_ue(0));
      end else put(0, 1);
      if ($urandom_range(0, 9) < 8) begin
        put(1, 1);
        case ($urandom_range(0, 5))
          0:       put(0, 32);
          1:       put(32'hFFFF_FFFF, 32);
          2:       put(1, 32);
          default: put($urandom_range(1, 5000), 32);
        endcase
        put(wide ? 32'hFFFF_FFFF : $urandom(), 32);
      end else put(0, 1);
    end else put(0, 1);
    put(1, 1);
    while (bits_q.size() % 8 != 0) put(0, 1);
    repeat ($urandom_range(0, 2)) put($urandom(), 8);
    for (int i = 0; i < bits_q.size(); i += 8) begin
      frame_q.insert(frame_q.size(), {bits_q[i], bits_q[i+1], bits_q[i+2], bits_q[i+3],
                                      bits_q[i+4], bits_q[i+5], bits_q[i+6], bits_q[i+7]});
    end
    if ($urandom_range(0, 9) == 0 && frame_q.size() > 1)
      repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send(frame_q[i], i == frame_q.size() - 1);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 600;
      hold_req = 1'b0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else out_tready <= quiet || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    geom_t got, want;
    got = out_tdata;
    if (rst_n && out_tvalid && out_tready) begin
      if (geom_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        want = geom_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("parse_ok exp %0d got %0d", want.ok, got.ok); errors++;
        end
        if (got.width !== want.width) begin
          $error("pic_width exp %0d got %0d", $signed(want.width), $signed(got.width)); errors++;
        end
        if (got.height !== want.height) begin
          $error("pic_height exp %0d got %0d", $signed(want.height), $signed(got.height));
          errors++;
        end
        if (got.ilace !== want.ilace) begin
          $error("interlaced exp %0d got %0d", want.ilace, got.ilace); errors++;
        end
        if (got.rate_ok !== want.rate_ok) begin
          $error("rate_present exp %0d got %0d", want.rate_ok, got.rate_ok); errors++;
        end
        if (got.rate !== want.rate) begin
          $error("frame_rate_q16 exp %0d got %0d", want.rate, got.rate); errors++;
        end
        if (got.pad !== 5'd0) begin
          $error("pad exp 0 got %0d", got.pad); errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cyc <= 0;
    else if (stall_cyc >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else stall_cyc <= stall_cyc + 1;
  end

  initial begin
    row_t  rows[$];
    geom_t g16;
    int    nframe;
    g16 = '0; g16.ok = 1; g16.width = 16; g16.height = 16;
    // lone bytes end before the syntax completes
    rows.insert(rows.size(), '{8'h42, 1, 1, '0});
    rows.insert(rows.size(), '{8'hFF, 1, 1, '0});
    rows.insert(rows.size(), '{8'h00, 1, 1, '0});
    // minimal baseline SPS: one macroblock, progressive, no VUI
    rows.insert(rows.size(), '{8'd66, 0, 0, '0});
    rows.insert(rows.size(), '{8'h00, 0, 0, '0});
    rows.insert(rows.size(), '{8'd30, 0, 0, '0});
    rows.insert(rows.size(), '{8'hDD, 0, 0, '0});
    rows.insert(rows.size(), '{8'hC4, 1, 1, g16});
    // exp-Golomb runaway: 32 zeros in the sps_id prefix
    rows.insert(rows.size(), '{8'd66, 0, 0, '0});
    rows.insert(rows.size(), '{8'hFF, 0, 0, '0});
    rows.insert(rows.size(), '{8'd30, 0, 0, '0});
    repeat (4) rows.insert(rows.size(), '{8'h00, 0, 0, '0});
    rows.insert(rows.size(), '{8'h80, 1, 1, '0});
    // trailing garbage after a complete syntax is ignored
    rows.insert(rows.size(), '{8'd66, 0, 0, '0});
    rows.insert(rows.size(), '{8'h00, 0, 0, '0});
    rows.insert(rows.size(), '{8'd30, 0, 0, '0});
    rows.insert(rows.size(), '{8'hDD, 0, 0, '0});
    rows.insert(rows.size(), '{8'hC7, 0, 0, '0});
    rows.insert(rows.size(), '{8'hFF, 1, 1, g16});

    sps_restart();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send(rows[i].d, rows[i].l, rows[i].typed, rows[i].g);
    repeat (4) begin build_sps(1); send_frame(); end

    nframe = 0;
    while (bytes_sent < RAND_BYTES) begin
      nframe++;
      quiet = (nframe >= 40 && nframe < 60);
      if (nframe == 70) hold_req = 1'b1;
      if (nframe == 90) drain();
      if ($urandom_range(0, 9) < 8) build_sps($urandom_range(0, 5) == 0);
      else begin
        frame_q.delete();
        repeat ($urandom_range(1, 6)) frame_q.insert(frame_q.size(), 8'($urandom()));
      end
      send_frame();
    end
    quiet = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (geom_q.size() != 0) begin
      $error("%0d results never arrived", geom_q.size());
      errors++;
    end
    $display("Sent %0d bytes in SPS frames: %0d parsed, %0d rejected or truncated.",
             bytes_sent, frames_ok, frames_bad);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
